// File: rtl/jqts_pkg.sv
// shared constants, base tables and pipeline types for the quantization table scaler
package jqts_pkg;

	// field and datapath widths
	localparam int QUAL_W  = 8;
	localparam int BASE_W  = 7;
	localparam int NUM_W   = 14;
	localparam int DIV_W   = 7;
	localparam int STEP_W  = 8;
	localparam int RECIP_W = 17;
	localparam int IDX_W   = 6;

	localparam logic [QUAL_W-1:0] QUAL_RESET = 8'd75;
	localparam logic [QUAL_W-1:0] QUAL_LO    = 8'd1;
	localparam logic [QUAL_W-1:0] QUAL_MID   = 8'd50;
	localparam logic [QUAL_W-1:0] QUAL_HI    = 8'd100;

	localparam logic [RECIP_W-1:0] RECIP_ONE = 17'h10000;
	localparam logic [STEP_W-1:0]  STEP_MAX  = 8'd255;

	// pipeline layout: one setup stage, then two long-division sections
	localparam int D1_STG  = 4;
	localparam int D2_STG  = 6;
	localparam int NUM_STG = 1 + D1_STG + D2_STG;
	localparam int D1_CNT [D1_STG] = '{4, 4, 3, 3};
	localparam int D2_CNT [D2_STG] = '{3, 3, 3, 3, 3, 2};

	// base tables, luminance in the lower half, chrominance in the upper half
	localparam logic [BASE_W-1:0] BASE_TAB [128] = '{
		7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
		7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
		7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
		7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
		7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
		7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
		7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
		7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99,
		7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
	};

	// state of the first divider: partial remainder, dividend bits shifting into quotient
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [NUM_W-1:0] work;
		logic [DIV_W-1:0] div;
	} div1_t;

	// state of the reciprocal divider
	typedef struct packed {
		logic [STEP_W-1:0]  step;
		logic [STEP_W-1:0]  rem;
		logic [RECIP_W-1:0] work;
	} div2_t;

endpackage

// File: rtl/jpeg_quant_table_scaler.sv
// one transaction per cycle sustained while m_tready does not stall the output
// the pipeline has eleven register stages: one setup stage, then the two long
// dividers spread over 4 and 6 pipeline stages
// a stalled output only holds the stages that are full; bubbles ahead of it still fill
// reset clears all stage valid bits and sets quality to 75
// quality-scaled jpeg quantization step and its 17-bit reciprocal
module jpeg_quant_table_scaler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,     // quality
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [5:0] entry_index, [7:6] zero
	input  logic [0:0]  s_tuser,       // [0] table_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // [7:0] scaled_step, [24:8] reciprocal_step, [31:25] zero
);

	localparam int NS = jqts_pkg::NUM_STG;
	localparam int D1 = jqts_pkg::D1_STG;
	localparam int D2 = jqts_pkg::D2_STG;

	logic [jqts_pkg::QUAL_W-1:0] quality_q;
	logic [NS-1:0]               vld_s;
	logic [NS-1:0]               rdy;

	jqts_pkg::div1_t setup_nx;
	jqts_pkg::div1_t in_s1;
	jqts_pkg::div1_t d1_nx [D1];
	jqts_pkg::div1_t d1_s  [D1];
	jqts_pkg::div2_t d2_nx [D2];
	jqts_pkg::div2_t d2_s  [D2];

	// quality register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quality_q <= jqts_pkg::QUAL_RESET;
		end else if (cfg_we) begin
			quality_q <= cfg_wdata;
		end
	end

	// per-stage ready: a stage takes new data when empty or when it moves on
	always_comb begin
		rdy[NS-1] = !vld_s[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// setup: base lookup and the exact fraction numerator / denominator
	always_comb begin
		logic [jqts_pkg::BASE_W-1:0] base;
		logic [jqts_pkg::DIV_W-1:0]  sc;
		base = jqts_pkg::BASE_TAB[{s_tuser[0], s_tdata[jqts_pkg::IDX_W-1:0]}];
		sc   = 7'(8'd200 - {quality_q[6:0], 1'b0});
		setup_nx.rem = '0;
		if (quality_q >= jqts_pkg::QUAL_LO && quality_q < jqts_pkg::QUAL_MID) begin
			// 50/q: (100*base + q) / (2q)
			setup_nx.work = 14'(base) * 14'd100 + 14'(quality_q);
			setup_nx.div  = {quality_q[5:0], 1'b0};
		end else if (quality_q >= jqts_pkg::QUAL_MID && quality_q <= jqts_pkg::QUAL_HI) begin
			// (200-2q)/100: (base*(200-2q) + 50) / 100
			setup_nx.work = 14'(base) * 14'(sc) + 14'd50;
			setup_nx.div  = 7'd100;
		end else begin
			// quality out of range: zero scale
			setup_nx.work = '0;
			setup_nx.div  = 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			in_s1 <= setup_nx;
		end
	end

	// first divider: restoring long division, a few quotient bits per stage
	for (genvar g = 0; g < D1; g++) begin : g_div1
		jqts_pkg::div1_t src;

		if (g == 0) begin : g_first
			assign src = in_s1;
		end else begin : g_next
			assign src = d1_s[g-1];
		end

		always_comb begin
			logic [jqts_pkg::DIV_W:0] t;
			d1_nx[g] = src;
			for (int i = 0; i < jqts_pkg::D1_CNT[g]; i++) begin
				t = {d1_nx[g].rem, d1_nx[g].work[jqts_pkg::NUM_W-1]};
				d1_nx[g].work = {d1_nx[g].work[jqts_pkg::NUM_W-2:0], 1'b0};
				if (t >= {1'b0, d1_nx[g].div}) begin
					d1_nx[g].rem     = 7'(t - {1'b0, d1_nx[g].div});
					d1_nx[g].work[0] = 1'b1;
				end else begin
					d1_nx[g].rem = t[jqts_pkg::DIV_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[1+g]) begin
				d1_s[g] <= d1_nx[g];
			end
		end
	end

	// reciprocal divider: 65536 / step, clamp of the step folded into its first stage
	for (genvar g = 0; g < D2; g++) begin : g_div2
		jqts_pkg::div2_t src;

		if (g == 0) begin : g_first
			always_comb begin
				logic [jqts_pkg::NUM_W-1:0] quot;
				quot     = d1_s[D1-1].work;
				src.rem  = '0;
				src.work = jqts_pkg::RECIP_ONE;
				if (quot == '0) begin
					src.step = 8'd1;
				end else if (quot > 14'(jqts_pkg::STEP_MAX)) begin
					src.step = jqts_pkg::STEP_MAX;
				end else begin
					src.step = quot[jqts_pkg::STEP_W-1:0];
				end
			end
		end else begin : g_next
			assign src = d2_s[g-1];
		end

		always_comb begin
			logic [jqts_pkg::STEP_W:0] t;
			d2_nx[g] = src;
			for (int i = 0; i < jqts_pkg::D2_CNT[g]; i++) begin
				t = {d2_nx[g].rem, d2_nx[g].work[jqts_pkg::RECIP_W-1]};
				d2_nx[g].work = {d2_nx[g].work[jqts_pkg::RECIP_W-2:0], 1'b0};
				if (t >= {1'b0, d2_nx[g].step}) begin
					d2_nx[g].rem     = 8'(t - {1'b0, d2_nx[g].step});
					d2_nx[g].work[0] = 1'b1;
				end else begin
					d2_nx[g].rem = t[jqts_pkg::STEP_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[1+D1+g]) begin
				d2_s[g] <= d2_nx[g];
			end
		end
	end

	// result transaction
	assign m_tvalid = vld_s[NS-1];
	assign m_tdata  = {7'b0, d2_s[D2-1].work, d2_s[D2-1].step};

endmodule
